// ===== rtl/uva_pkg.sv =====
// ---------------------------------------------------------------------------
// uva_pkg
// Shared widths, constants, pipeline payload types and the stage angle
// function for the unit vector angle pipeline.
// ---------------------------------------------------------------------------
package uva_pkg;

  // fixed point format of the result and number of rotation cells
  localparam int FRAC_BITS       = 14;
  localparam int ROTATION_STAGES = 16;

  // field widths
  localparam int IN_W    = 16;
  localparam int ANGLE_W = 16;

  // internal widths
  localparam int PROD_W     = 2 * IN_W;     // one component product
  localparam int DOT_W      = PROD_W + 2;   // sum of three products
  localparam int CROSS_W    = PROD_W + 1;   // difference of two products
  localparam int MAG_W      = PROD_W;       // magnitude of a cross component
  localparam int SQ_W       = 2 * MAG_W;    // squared length, wraps mod 2^64
  localparam int SQRT_STEPS = SQ_W / 2;     // one root bit per cell
  localparam int ROOT_W     = SQRT_STEPS + 1;
  localparam int U_W        = ROOT_W;       // operand width before scaling
  localparam int NORM_W     = 57;           // scaled operands lie in [2^56, 2^57)
  localparam int NORM_STEPS = 6;            // shifts of 32, 16, 8, 4, 2, 1
  localparam int SH_W       = 6;
  localparam int XY_W       = NORM_W + 4;   // headroom for the rotation gain
  localparam int Z_W        = 63;           // signed angle accumulator, Q60
  localparam int ANG_W      = 62;           // stage angle constant, Q60
  localparam int STEP_W     = 5;            // cell index, up to 32 cells

  // pi in Q60 and derived constants
  localparam logic [63:0]      PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [ANG_W-1:0] PI_ANG   = PI_Q60[ANG_W-1:0];
  localparam logic [63:0]      PI_HALF  = (PI_Q60 + 64'd1) >> 1;
  localparam int               ROUND_SH = 60 - FRAC_BITS;

  // square root pipeline payload
  typedef struct packed {
    logic                    valid;
    logic [SQ_W-1:0]         rem;
    logic [SQ_W-1:0]         root;
    logic signed [DOT_W-1:0] dot;
  } sqrt_t;

  // scaling pipeline payload
  typedef struct packed {
    logic                  valid;
    logic                  zero;
    logic [NORM_W-1:0]     ux;
    logic [NORM_W-1:0]     uy;
    logic [NORM_W-1:0]     m;
    logic signed [Z_W-1:0] z;
  } norm_t;

  // rotation pipeline payload
  typedef struct packed {
    logic                   valid;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // atan(2^-i) in Q60, from the alternating series in Q62, rounded
  function automatic logic [ANG_W-1:0] stage_angle(input int unsigned i);
    logic [63:0] acc;
    logic [63:0] t;
    int unsigned e;
    acc = 64'd0;
    if (i == 0) begin
      return ANG_W'((PI_Q60 + 64'd2) >> 2);
    end
    for (int unsigned k = 0; k < 32; k++) begin
      e = (2 * k + 1) * i;
      if (e <= 62) begin
        t = (64'd1 << (62 - e)) / 64'(2 * k + 1);
        acc = k[0] ? acc - t : acc + t;
      end
    end
    return ANG_W'((acc + 64'd2) >> 2);
  endfunction

endpackage

// ===== rtl/uva_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// uva_sqrt_cell
// One cell of the integer square root chain: settles one root bit per cycle
// and carries the dot product alongside.
// ---------------------------------------------------------------------------
module uva_sqrt_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [uva_pkg::STEP_W-1:0]          step,
  input  uva_pkg::sqrt_t                      din,
  output uva_pkg::sqrt_t                      dout
);

  logic [uva_pkg::SQ_W-1:0] bitv;
  logic [uva_pkg::SQ_W:0]   trial;
  logic                     take;
  uva_pkg::sqrt_t           res_next;

  // trial subtraction of root plus the current bit weight
  always_comb begin
    bitv     = uva_pkg::SQ_W'(1) << (6'd62 - {step, 1'b0});
    trial    = {1'b0, din.root} + {1'b0, bitv};
    take     = {1'b0, din.rem} >= trial;
    res_next = din;
    if (take) begin
      res_next.rem  = din.rem - trial[uva_pkg::SQ_W-1:0];
      res_next.root = (din.root >> 1) + bitv;
    end else begin
      res_next.root = din.root >> 1;
    end
  end

  // request valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    dout.rem  <= res_next.rem;
    dout.root <= res_next.root;
    dout.dot  <= res_next.dot;
  end

endmodule

// ===== rtl/uva_norm_cell.sv =====
// ---------------------------------------------------------------------------
// uva_norm_cell
// One cell of the scaling chain: shifts the operand pair left by a fixed
// amount when the larger one still fits below the top bit.
// ---------------------------------------------------------------------------
module uva_norm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [uva_pkg::SH_W-1:0]   sh,
  input  uva_pkg::norm_t             din,
  output uva_pkg::norm_t             dout
);

  logic           fits;
  uva_pkg::norm_t res_next;

  // shift only when the larger operand stays below 2^57
  always_comb begin
    fits     = (din.m >> (6'(uva_pkg::NORM_W) - sh)) == '0;
    res_next = din;
    if (fits) begin
      res_next.ux = din.ux << sh;
      res_next.uy = din.uy << sh;
      res_next.m  = din.m << sh;
    end
  end

  // request valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    dout.zero <= res_next.zero;
    dout.ux   <= res_next.ux;
    dout.uy   <= res_next.uy;
    dout.m    <= res_next.m;
    dout.z    <= res_next.z;
  end

endmodule

// ===== rtl/uva_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// uva_cordic_cell
// One vectoring rotation cell: turns the pair towards the x axis by
// atan(2^-step) and accumulates the angle.
// ---------------------------------------------------------------------------
module uva_cordic_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [uva_pkg::STEP_W-1:0]  step,
  input  logic [uva_pkg::ANG_W-1:0]   ang,
  input  uva_pkg::cordic_t            din,
  output uva_pkg::cordic_t            dout
);

  logic signed [uva_pkg::XY_W-1:0] xs;
  logic signed [uva_pkg::XY_W-1:0] ys;
  logic signed [uva_pkg::Z_W-1:0]  az;
  uva_pkg::cordic_t                res_next;

  // floor shifts, direction from the sign of y
  always_comb begin
    xs       = din.x >>> step;
    ys       = din.y >>> step;
    az       = $signed({1'b0, ang});
    res_next = din;
    if (!din.y[uva_pkg::XY_W-1]) begin
      res_next.x = din.x + ys;
      res_next.y = din.y - xs;
      res_next.z = din.z + az;
    end else begin
      res_next.x = din.x - ys;
      res_next.y = din.y + xs;
      res_next.z = din.z - az;
    end
  end

  // request valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    dout.zero <= res_next.zero;
    dout.x    <= res_next.x;
    dout.y    <= res_next.y;
    dout.z    <= res_next.z;
  end

endmodule

// ===== rtl/unit_vector_angle.sv =====
// ---------------------------------------------------------------------------
// unit_vector_angle
// Angle between two 3D direction vectors: dot and cross products, integer
// square root chain, operand scaling chain and vectoring rotation chain.
// ---------------------------------------------------------------------------
//
// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------
// request   | start / busy       | a_x a_y a_z b_x b_y b_z (signed Q1.14)
// result    | done (one cycle)   | angle (unsigned, 14 fraction bits)
//
// One request is taken every clock cycle; busy is always low.
// Each request passes through four product and sum stages, 32 square root
// cells, one select stage, six scaling cells, 16 rotation cells and the
// output register, and its result appears with done.
// Results leave in request order and cannot be held off by the receiver.
// Reset clears only the valid flags of the pipeline.
// ---------------------------------------------------------------------------
module unit_vector_angle (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [uva_pkg::IN_W-1:0]    a_x,
  input  logic signed [uva_pkg::IN_W-1:0]    a_y,
  input  logic signed [uva_pkg::IN_W-1:0]    a_z,
  input  logic signed [uva_pkg::IN_W-1:0]    b_x,
  input  logic signed [uva_pkg::IN_W-1:0]    b_y,
  input  logic signed [uva_pkg::IN_W-1:0]    b_z,
  output logic                               done,
  output logic [uva_pkg::ANGLE_W-1:0]        angle
);

  // product stage
  logic                                s1_valid;
  logic signed [uva_pkg::PROD_W-1:0]   p_dx, p_dy, p_dz;
  logic signed [uva_pkg::PROD_W-1:0]   p_ybz, p_zby, p_zbx, p_xbz, p_xby, p_ybx;

  // sum stage
  logic                                s2_valid;
  logic signed [uva_pkg::DOT_W-1:0]    s2_dot;
  logic [uva_pkg::MAG_W-1:0]           mag_x, mag_y, mag_z;
  logic signed [uva_pkg::CROSS_W-1:0]  cx, cy, cz;
  logic signed [uva_pkg::CROSS_W-1:0]  ncx, ncy, ncz;

  // square stage
  logic                                s3_valid;
  logic signed [uva_pkg::DOT_W-1:0]    s3_dot;
  logic [uva_pkg::SQ_W-1:0]            sq_x, sq_y, sq_z;

  // square root chain
  uva_pkg::sqrt_t                      sq_pipe [uva_pkg::SQRT_STEPS+1];

  // select stage
  uva_pkg::sqrt_t                      sq_last;
  logic [uva_pkg::U_W-1:0]             sine;
  logic [uva_pkg::U_W-1:0]             neg_dot;
  logic [uva_pkg::U_W-1:0]             ux, uy, um;
  logic signed [uva_pkg::Z_W-1:0]      z0;
  uva_pkg::norm_t                      nm_pipe [uva_pkg::NORM_STEPS+1];

  // rotation chain
  uva_pkg::cordic_t                    cr_pipe [uva_pkg::ROTATION_STAGES+1];

  // output stage
  uva_pkg::cordic_t                    cr_last;
  logic [uva_pkg::ANG_W-1:0]           z_clamp;
  logic [uva_pkg::ANG_W:0]             z_round;

  assign busy = 1'b0;

  // request valid through the arithmetic front end
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // component products
  always_ff @(posedge clk) begin
    p_dx  <= a_x * b_x;
    p_dy  <= a_y * b_y;
    p_dz  <= a_z * b_z;
    p_ybz <= a_y * b_z;
    p_zby <= a_z * b_y;
    p_zbx <= a_z * b_x;
    p_xbz <= a_x * b_z;
    p_xby <= a_x * b_y;
    p_ybx <= a_y * b_x;
  end

  // cross components and their magnitudes
  always_comb begin
    cx  = uva_pkg::CROSS_W'(p_ybz) - uva_pkg::CROSS_W'(p_zby);
    cy  = uva_pkg::CROSS_W'(p_zbx) - uva_pkg::CROSS_W'(p_xbz);
    cz  = uva_pkg::CROSS_W'(p_xby) - uva_pkg::CROSS_W'(p_ybx);
    ncx = -cx;
    ncy = -cy;
    ncz = -cz;
  end

  // dot sum and cross magnitudes
  always_ff @(posedge clk) begin
    s2_dot <= uva_pkg::DOT_W'(p_dx) + uva_pkg::DOT_W'(p_dy) + uva_pkg::DOT_W'(p_dz);
    mag_x  <= cx[uva_pkg::CROSS_W-1] ? ncx[uva_pkg::MAG_W-1:0] : cx[uva_pkg::MAG_W-1:0];
    mag_y  <= cy[uva_pkg::CROSS_W-1] ? ncy[uva_pkg::MAG_W-1:0] : cy[uva_pkg::MAG_W-1:0];
    mag_z  <= cz[uva_pkg::CROSS_W-1] ? ncz[uva_pkg::MAG_W-1:0] : cz[uva_pkg::MAG_W-1:0];
  end

  // squares of the cross components
  always_ff @(posedge clk) begin
    s3_dot <= s2_dot;
    sq_x   <= mag_x * mag_x;
    sq_y   <= mag_y * mag_y;
    sq_z   <= mag_z * mag_z;
  end

  // squared cross length enters the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_pipe[0].valid <= 1'b0;
    end else begin
      sq_pipe[0].valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_pipe[0].rem  <= sq_x + sq_y + sq_z;
    sq_pipe[0].root <= '0;
    sq_pipe[0].dot  <= s3_dot;
  end

  // square root chain, one root bit per cell
  for (genvar j = 0; j < uva_pkg::SQRT_STEPS; j++) begin : g_sqrt
    uva_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (uva_pkg::STEP_W'(j)),
      .din  (sq_pipe[j]),
      .dout (sq_pipe[j+1])
    );
  end

  // pick the half plane and the pair for the rotation chain
  always_comb begin
    sq_last = sq_pipe[uva_pkg::SQRT_STEPS];
    sine    = sq_last.root[uva_pkg::U_W-1:0];
    neg_dot = uva_pkg::U_W'(-sq_last.dot);
    if (!sq_last.dot[uva_pkg::DOT_W-1]) begin
      ux = uva_pkg::U_W'(sq_last.dot);
      uy = sine;
      z0 = '0;
    end else begin
      ux = sine;
      uy = neg_dot;
      z0 = uva_pkg::Z_W'(uva_pkg::PI_HALF);
    end
    um = (ux > uy) ? ux : uy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_pipe[0].valid <= 1'b0;
    end else begin
      nm_pipe[0].valid <= sq_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    nm_pipe[0].zero <= (um == '0);
    nm_pipe[0].ux   <= uva_pkg::NORM_W'(ux);
    nm_pipe[0].uy   <= uva_pkg::NORM_W'(uy);
    nm_pipe[0].m    <= uva_pkg::NORM_W'(um);
    nm_pipe[0].z    <= z0;
  end

  // scaling chain, halving shift steps
  for (genvar k = 0; k < uva_pkg::NORM_STEPS; k++) begin : g_norm
    uva_norm_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .sh   (uva_pkg::SH_W'(1) << (uva_pkg::NORM_STEPS - 1 - k)),
      .din  (nm_pipe[k]),
      .dout (nm_pipe[k+1])
    );
  end

  // scaled pair starts the rotation chain
  always_comb begin
    cr_pipe[0].valid = nm_pipe[uva_pkg::NORM_STEPS].valid;
    cr_pipe[0].zero  = nm_pipe[uva_pkg::NORM_STEPS].zero;
    cr_pipe[0].x     = $signed(uva_pkg::XY_W'(nm_pipe[uva_pkg::NORM_STEPS].ux));
    cr_pipe[0].y     = $signed(uva_pkg::XY_W'(nm_pipe[uva_pkg::NORM_STEPS].uy));
    cr_pipe[0].z     = nm_pipe[uva_pkg::NORM_STEPS].z;
  end

  // rotation chain
  for (genvar i = 0; i < uva_pkg::ROTATION_STAGES; i++) begin : g_rot
    localparam logic [uva_pkg::ANG_W-1:0] ANG = uva_pkg::stage_angle(i);
    uva_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (uva_pkg::STEP_W'(i)),
      .ang  (ANG),
      .din  (cr_pipe[i]),
      .dout (cr_pipe[i+1])
    );
  end

  // clamp to 0..pi and round to the output format
  always_comb begin
    cr_last = cr_pipe[uva_pkg::ROTATION_STAGES];
    if (cr_last.z[uva_pkg::Z_W-1]) begin
      z_clamp = '0;
    end else if (cr_last.z > $signed({1'b0, uva_pkg::PI_ANG})) begin
      z_clamp = uva_pkg::PI_ANG;
    end else begin
      z_clamp = cr_last.z[uva_pkg::ANG_W-1:0];
    end
    z_round = ({1'b0, z_clamp} + ((uva_pkg::ANG_W+1)'(1) << (uva_pkg::ROUND_SH - 1)))
              >> uva_pkg::ROUND_SH;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cr_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    angle <= cr_last.zero ? '0 : z_round[uva_pkg::ANGLE_W-1:0];
  end

endmodule

// ===== tb/tb_unit_vector_angle.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_unit_vector_angle
// Self-checking bench for the vector angle pipeline. A scoreboard class
// predicts the CORDIC angle of every accepted request in 64-bit integer
// arithmetic and compares it with each strobed result in order. Directed
// pairs cover zero, parallel, antiparallel, perpendicular and extreme
// components; the random part mixes unit, near-parallel, raw, extreme and zero pairs.
// ---------------------------------------------------------------------------
module tb_unit_vector_angle;

  localparam int RANDOM_REQUESTS = 1250;
  localparam int CALM_TAIL       = 150;   // last requests sent back to back
  localparam int DRAIN_CYCLES    = 80;    // pipeline depth plus margin
  localparam int STALL_LIMIT     = 2000;  // cycles without any transfer

  typedef struct {
    logic signed [uva_pkg::IN_W-1:0] x;
    logic signed [uva_pkg::IN_W-1:0] y;
    logic signed [uva_pkg::IN_W-1:0] z;
  } vec3_t;

  // expected angle store and predictor
  class angle_scoreboard;
    logic [uva_pkg::ANGLE_W-1:0] expected_angles[$];
    int unsigned                 request_tags[$];
    int unsigned                 request_count;
    int unsigned                 error_count;
    longint                      stage_atan[32];

    function new();
      request_count = 0;
      error_count   = 0;
      for (int i = 0; i < 32; i++) begin
        stage_atan[i] = arctan_step(i);
      end
    endfunction

    // atan(2^-i) in Q60 from the alternating series in Q62
    function longint arctan_step(int unsigned i);
      logic [63:0] acc;
      logic [63:0] term;
      int unsigned e;
      acc = 64'd0;
      if (i == 0) begin
        return longint'((uva_pkg::PI_Q60 + 64'd2) >> 2);
      end
      for (int unsigned k = 0; k < 32; k++) begin
        e = (2 * k + 1) * i;
        if (e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * k + 1);
          acc  = k[0] ? acc - term : acc + term;
        end
      end
      return longint'((acc + 64'd2) >> 2);
    endfunction

    // floor square root of a 64-bit value
    function logic [63:0] root_floor(logic [63:0] n);
      logic [63:0] res;
      logic [63:0] probe;
      res   = 64'd0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
        if (n >= res + probe) begin
          n   = n - (res + probe);
          res = (res >> 1) + probe;
        end else begin
          res = res >> 1;
        end
        probe = probe >> 2;
      end
      return res;
    endfunction

    function logic [uva_pkg::ANGLE_W-1:0] predict_angle(
        logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
        logic signed [15:0] bx, logic signed [15:0] by, logic signed [15:0] bz);
      longint      dot, cx, cy, cz, x, y, z, nx, pi_q60;
      logic [63:0] sq, sine, ux, uy, mx, zr;
      pi_q60 = longint'(uva_pkg::PI_Q60);
      dot  = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by)
             + longint'(az) * longint'(bz);
      cx   = longint'(ay) * longint'(bz) - longint'(az) * longint'(by);
      cy   = longint'(az) * longint'(bx) - longint'(ax) * longint'(bz);
      cz   = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
      sq   = cx * cx + cy * cy + cz * cz;
      sine = root_floor(sq);
      // negative cosine: quarter turn first, then add pi/2
      if (dot >= 0) begin
        ux = dot;
        uy = sine;
        z  = 0;
      end else begin
        ux = sine;
        uy = -dot;
        z  = longint'((uva_pkg::PI_Q60 + 64'd1) >> 1);
      end
      if (ux == 0 && uy == 0) begin
        return '0;
      end
      // scale so the larger operand lies in [2^56, 2^57)
      mx = (ux > uy) ? ux : uy;
      while (mx < (64'd1 << 56)) begin
        mx = mx << 1;
        ux = ux << 1;
        uy = uy << 1;
      end
      x = longint'(ux);
      y = longint'(uy);
      // vectoring rotations, shifts round toward minus infinity
      for (int i = 0; i < uva_pkg::ROTATION_STAGES && i < 32; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + stage_atan[i];
        end else begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - stage_atan[i];
        end
        x = nx;
      end
      if (z < 0) z = 0;
      if (z > pi_q60) z = pi_q60;
      zr = (64'(z) + (64'd1 << (59 - uva_pkg::FRAC_BITS))) >> (60 - uva_pkg::FRAC_BITS);
      return zr[uva_pkg::ANGLE_W-1:0];
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      error_count++;
    endtask

    function void note_request(
        logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az,
        logic signed [15:0] bx, logic signed [15:0] by, logic signed [15:0] bz);
      expected_angles.push_back(predict_angle(ax, ay, az, bx, by, bz));
      request_tags.push_back(request_count);
      request_count++;
    endfunction

    task check_result(logic [uva_pkg::ANGLE_W-1:0] got);
      logic [uva_pkg::ANGLE_W-1:0] want;
      int unsigned                 tag;
      if (expected_angles.size() == 0) begin
        report($sformatf("result angle=%0d with no request pending", got));
      end else begin
        want = expected_angles.pop_front();
        tag  = request_tags.pop_front();
        if (got !== want) begin
          report($sformatf("request %0d: angle=%0d, expected %0d", tag, got, want));
        end
      end
    endtask

    function int pending();
      return expected_angles.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [uva_pkg::IN_W-1:0] a_x = '0;
  logic signed [uva_pkg::IN_W-1:0] a_y = '0;
  logic signed [uva_pkg::IN_W-1:0] a_z = '0;
  logic signed [uva_pkg::IN_W-1:0] b_x = '0;
  logic signed [uva_pkg::IN_W-1:0] b_y = '0;
  logic signed [uva_pkg::IN_W-1:0] b_z = '0;
  logic done;
  logic [uva_pkg::ANGLE_W-1:0] angle;

  angle_scoreboard sb = new();
  int              stall_cycles = 0;

  unit_vector_angle dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .a_x   (a_x),
    .a_y   (a_y),
    .a_z   (a_z),
    .b_x   (b_x),
    .b_y   (b_y),
    .b_z   (b_z),
    .done  (done),
    .angle (angle)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitor: accepted requests, strobed results and the stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_request(a_x, a_y, a_z, b_x, b_y, b_z);
      end
      if (done) begin
        sb.check_result(angle);
      end
      if ((start && !busy) || done) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic vec3_t v3(int x, int y, int z);
    vec3_t v;
    v.x = uva_pkg::IN_W'(x);
    v.y = uva_pkg::IN_W'(y);
    v.z = uva_pkg::IN_W'(z);
    return v;
  endfunction

  // scale a real direction to Q1.14
  function automatic vec3_t to_unit(real gx, real gy, real gz);
    real n;
    n = $sqrt(gx * gx + gy * gy + gz * gz);
    if (n < 1.0e-9) begin
      return v3(16384, 0, 0);
    end
    gx = gx / n * 16384.0;
    gy = gy / n * 16384.0;
    gz = gz / n * 16384.0;
    return v3($rtoi(gx + (gx >= 0.0 ? 0.5 : -0.5)), $rtoi(gy + (gy >= 0.0 ? 0.5 : -0.5)),
              $rtoi(gz + (gz >= 0.0 ? 0.5 : -0.5)));
  endfunction

  function automatic real rand_coord(int span);
    return real'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic vec3_t rand_unit();
    return to_unit(rand_coord(10000), rand_coord(10000), rand_coord(10000));
  endfunction

  // small random tilt of a direction, optionally reversed
  function automatic vec3_t tilt(vec3_t a, int spread, bit flip);
    real s;
    s = flip ? -1.0 : 1.0;
    return to_unit(s * real'(a.x) + rand_coord(spread), s * real'(a.y) + rand_coord(spread),
                   s * real'(a.z) + rand_coord(spread));
  endfunction

  function automatic logic signed [15:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return -16'sd32768;
      1:       return -16'sd16384;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd16384;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic vec3_t rand_raw();
    return v3(int'($urandom), int'($urandom), int'($urandom));
  endfunction

  // one request: held until start is seen with busy low
  task send_pair(vec3_t a, vec3_t b);
    start <= 1'b1;
    a_x   <= a.x;
    a_y   <= a.y;
    a_z   <= a.z;
    b_x   <= b.x;
    b_y   <= b.y;
    b_z   <= b.z;
    do @(posedge clk); while (busy);
  endtask

  // sender gap with junk on the fields
  task idle_burst(int cycles);
    start <= 1'b0;
    a_x   <= uva_pkg::IN_W'($urandom);
    a_y   <= uva_pkg::IN_W'($urandom);
    a_z   <= uva_pkg::IN_W'($urandom);
    b_x   <= uva_pkg::IN_W'($urandom);
    b_y   <= uva_pkg::IN_W'($urandom);
    b_z   <= uva_pkg::IN_W'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  task hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    vec3_t a, b;
    int    pick, idle_pct;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs
    send_pair(v3(0, 0, 0), v3(0, 0, 0));
    send_pair(v3(0, 0, 0), v3(16384, 0, 0));
    send_pair(v3(16384, 0, 0), v3(16384, 0, 0));
    send_pair(v3(16384, 0, 0), v3(-16384, 0, 0));
    send_pair(v3(16384, 0, 0), v3(0, 16384, 0));
    send_pair(v3(16384, 0, 0), v3(-11585, 11585, 0));
    send_pair(v3(16384, 0, 0), v3(11585, 11585, 0));
    send_pair(v3(-32768, -32768, -32768), v3(-32768, -32768, -32768));
    send_pair(v3(-32768, -32768, -32768), v3(32767, 32767, 32767));
    send_pair(v3(32767, 32767, 32767), v3(32767, 32767, 32767));
    send_pair(v3(32767, -32768, 0), v3(-32768, 32767, 0));
    send_pair(v3(32767, 32767, -32768), v3(-32768, 32767, 32767));
    send_pair(v3(16384, 0, 0), v3(16384, 1, 0));
    send_pair(v3(16384, 0, 0), v3(-16384, 1, 0));
    send_pair(v3(0, 0, 16384), v3(0, 16384, 0));
    send_pair(v3(-16384, 0, 0), v3(0, 0, -16384));
    send_pair(v3(9459, 9459, 9459), v3(-9459, -9459, -9459));
    send_pair(v3(16384, 0, 0), v3(-11585, 0, -11585));
    send_pair(v3(0, 16384, 0), v3(0, 0, 0));
    send_pair(v3(1, 2, 3), v3(-2, 1, 0));
    send_pair(v3(1, 0, 0), v3(0, 0, 1));
    send_pair(v3(16384, 0, 0), v3(11585, -11584, 1));
    send_pair(v3(-32768, 0, 0), v3(16384, -32768, 32767));

    // every result of the directed part before the random part
    hold_until_drained();

    idle_pct = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      a = rand_unit();
      if (pick < 45) begin
        b = rand_unit();
      end else if (pick < 60) begin
        b = tilt(a, $urandom_range(1, 300), 1'($urandom_range(0, 1)));
      end else if (pick < 68) begin
        // exact copies and reversals, with a stray LSB now and then
        b = a;
        if ($urandom_range(0, 1)) b = v3(int'(-a.x), int'(-a.y), int'(-a.z));
        if ($urandom_range(0, 2) == 0) b.y = b.y + 16'sd1;
      end else if (pick < 80) begin
        a = rand_raw();
        b = rand_raw();
      end else if (pick < 88) begin
        a = v3(int'(pick_extreme()), int'(pick_extreme()), int'(pick_extreme()));
        b = v3(int'(pick_extreme()), int'(pick_extreme()), int'(pick_extreme()));
      end else if (pick < 94) begin
        // zero dot product
        b = v3(int'(-a.y), int'(a.x), 0);
        if ($urandom_range(0, 1)) b = v3(int'(-b.x), int'(-b.y), 0);
      end else begin
        b = $urandom_range(0, 1) ? v3(0, 0, 0) : a;
        if ($urandom_range(0, 1)) a = v3(0, 0, 0);
      end

      // sender idling varies per window, none in the tail
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 8;
          default: idle_pct = 30;
        endcase
      end
      if (n == RANDOM_REQUESTS / 2) begin
        hold_until_drained();
      end else if (n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
        idle_burst($urandom_range(1, 10));
      end
      send_pair(a, b);
    end

    // drain, then watch for stray strobes
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
